// ===== src/dwsd_pkg.sv =====
// Shared types and constants for the dual-window spike detector.
package dwsd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int THR_W     = 17;
    localparam int CFG_IDX_W = 2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [THR_W-1:0]    thr_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_FRACTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_POWER     = 2'd2;

    localparam sample_t MIN_POWER_RESET      = 16'd0;
    localparam thr_t    SPIKE_FRACTION_RESET = 17'd9830;
    localparam sample_t SEED_RESET           = 16'd1000;
    localparam sample_t SHORT_SEED_RESET     = sample_t'((1000 * 4) / 5);

    // Fixed 0.5 threshold with 16 fraction bits.
    localparam thr_t HALF_THR = 17'd32768;

    // 0.8 in 16 fraction bits, rounded up; floor((s * 52429) >> 16) equals
    // floor(4s/5) for every 16-bit s.
    localparam sample_t FOUR_FIFTHS_Q16 = 16'd52429;

endpackage

// ===== src/dwsd_cell.sv =====
// One window entry: a register that takes its neighbour's value on a shift.
module dwsd_cell #(
    parameter dwsd_pkg::sample_t RESET_VAL = '0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  dwsd_pkg::sample_t d,
    output dwsd_pkg::sample_t q
);

    dwsd_pkg::sample_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= RESET_VAL;
        end else if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== src/dwsd_window.sv =====
// Sliding window built as a row of cells, with its running sum and mean.
module dwsd_window #(
    parameter int                LEN       = 8,
    parameter dwsd_pkg::sample_t RESET_VAL = '0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  dwsd_pkg::sample_t din,
    output dwsd_pkg::sample_t mean
);

    localparam int SUM_W = dwsd_pkg::SAMPLE_W + $clog2(LEN);
    localparam int SH    = $clog2(LEN + 1) - 1;
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(RESET_VAL * LEN);

    dwsd_pkg::sample_t  taps [LEN];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   shifted;

    for (genvar i = 0; i < LEN; i++) begin : g_cell
        dwsd_cell #(
            .RESET_VAL (RESET_VAL)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d        ((i == 0) ? din : taps[(i == 0) ? 0 : i - 1]),
            .q        (taps[i])
        );
    end

    // The last cell holds the oldest entry, which leaves as the new one enters.
    assign sum_next = sum_reg - SUM_W'(taps[LEN-1]) + SUM_W'(din);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= SUM_RESET;
        end else if (shift_en) begin
            sum_reg <= sum_next;
        end
    end

    assign shifted = sum_reg >> SH;

    always_comb begin
        if (shifted > SUM_W'({dwsd_pkg::SAMPLE_W{1'b1}})) begin
            mean = '1;
        end else begin
            mean = shifted[dwsd_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ===== src/dual_window_spike_detector_core.sv =====
// Top level of the dual-window spike detector: control, registers and alert test.
//
// After a power sample's beat is accepted, state UPDATE shifts the sample into both
// cell rows and updates the running sums, if the sample reaches the minimum power.
// State MULT registers the 17 x 16 threshold multiply. State DONE does the compare
// and loads the output register in the same cycle, once the output register is free.
// A restart's result is loaded after the seed values are shifted through the cell
// rows one entry per cycle. One item is in work at a time, so a sample holds the
// input channel until its result is loaded. A new item is accepted while the
// previous result still waits in the output register. Configuration writes are
// taken in every cycle.
module dual_window_spike_detector_core #(
    parameter int SHORT_LEN = 8,
    parameter int LONG_LEN  = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [15:0]                     s_power_sample,
    input  logic                            s_acceleration_active,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_alert,
    output logic                            m_sample_taken,
    output logic [15:0]                     m_short_average,
    output logic [15:0]                     m_long_average,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwsd_pkg::THR_W-1:0]      cfg_data
);

    localparam int RUN_LEN = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int CNT_W   = $clog2(RUN_LEN);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_UPDATE    = 3'd1;
    localparam logic [2:0] ST_MULT      = 3'd2;
    localparam logic [2:0] ST_SEED_PREP = 3'd3;
    localparam logic [2:0] ST_SEED_RUN  = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    run_cnt_reg, run_cnt_next;

    dwsd_pkg::sample_t   min_power_reg;
    dwsd_pkg::thr_t      spike_fraction_reg;
    dwsd_pkg::sample_t   seed_power_reg;

    logic                func_reg;
    dwsd_pkg::sample_t   power_reg;
    logic                accel_reg;
    logic                taken_reg, taken_next;
    dwsd_pkg::sample_t   short_seed_reg;
    logic [31:0]         seed_prod;

    logic [32:0]         prod_reg;
    dwsd_pkg::sample_t   diff_reg;
    logic                rise_reg;
    dwsd_pkg::thr_t      thr;

    logic                m_valid_reg;
    logic                alert_reg;
    logic                taken_out_reg;
    dwsd_pkg::sample_t   short_avg_reg;
    dwsd_pkg::sample_t   long_avg_reg;

    logic                shift_en;
    dwsd_pkg::sample_t   short_din;
    dwsd_pkg::sample_t   long_din;
    dwsd_pkg::sample_t   short_mean;
    dwsd_pkg::sample_t   long_mean;
    logic                load_out;
    logic                alert_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_power_reg      <= dwsd_pkg::MIN_POWER_RESET;
            spike_fraction_reg <= dwsd_pkg::SPIKE_FRACTION_RESET;
            seed_power_reg     <= dwsd_pkg::SEED_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dwsd_pkg::CFG_MIN_POWER: begin
                    min_power_reg <= cfg_data[dwsd_pkg::SAMPLE_W-1:0];
                end
                dwsd_pkg::CFG_SPIKE_FRACTION: begin
                    spike_fraction_reg <= cfg_data;
                end
                dwsd_pkg::CFG_SEED_POWER: begin
                    seed_power_reg <= cfg_data[dwsd_pkg::SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign taken_next = (power_reg >= min_power_reg);
    assign seed_prod  = seed_power_reg * dwsd_pkg::FOUR_FIFTHS_Q16;

    always_comb begin
        shift_en  = 1'b0;
        short_din = power_reg;
        long_din  = power_reg;
        if (state_reg == ST_UPDATE) begin
            shift_en = taken_next;
        end else if (state_reg == ST_SEED_RUN) begin
            shift_en  = 1'b1;
            short_din = short_seed_reg;
            long_din  = seed_power_reg;
        end
    end

    dwsd_window #(
        .LEN       (SHORT_LEN),
        .RESET_VAL (dwsd_pkg::SHORT_SEED_RESET)
    ) u_short (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (shift_en),
        .din      (short_din),
        .mean     (short_mean)
    );

    dwsd_window #(
        .LEN       (LONG_LEN),
        .RESET_VAL (dwsd_pkg::SEED_RESET)
    ) u_long (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (shift_en),
        .din      (long_din),
        .mean     (long_mean)
    );

    assign thr      = accel_reg ? dwsd_pkg::HALF_THR : spike_fraction_reg;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign alert_next = taken_reg && rise_reg &&
                        ({1'b0, diff_reg, 16'h0000} > prod_reg);

    always_comb begin
        state_next   = state_reg;
        run_cnt_next = run_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_func ? ST_SEED_PREP : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_DONE;
            end
            ST_SEED_PREP: begin
                state_next   = ST_SEED_RUN;
                run_cnt_next = '0;
            end
            ST_SEED_RUN: begin
                if (run_cnt_reg == CNT_W'(RUN_LEN - 1)) begin
                    state_next   = ST_DONE;
                    run_cnt_next = '0;
                end else begin
                    run_cnt_next = run_cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            taken_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_cnt_reg <= run_cnt_next;
            if (state_reg == ST_UPDATE) begin
                taken_reg <= taken_next;
            end else if (state_reg == ST_SEED_PREP) begin
                taken_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            power_reg <= s_power_sample;
            accel_reg <= s_acceleration_active;
        end
        if (state_reg == ST_SEED_PREP) begin
            short_seed_reg <= seed_prod[31:16];
        end
        if (state_reg == ST_MULT) begin
            prod_reg <= thr * short_mean;
            diff_reg <= short_mean - long_mean;
            rise_reg <= (short_mean != '0) && (short_mean > long_mean);
        end
        if (load_out) begin
            alert_reg     <= alert_next;
            taken_out_reg <= taken_reg && !func_reg;
            short_avg_reg <= short_mean;
            long_avg_reg  <= long_mean;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_alert         = alert_reg;
    assign m_sample_taken  = taken_out_reg;
    assign m_short_average = short_avg_reg;
    assign m_long_average  = long_avg_reg;

    // An accepted beat holds the block busy for at least the following cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat accepted while an item was in work");

    // An alert only ever comes with a sample that entered the windows.
    a_alert_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alert) |-> m_sample_taken)
        else $error("alert without a taken sample");

    // An alert means the short mean stands above the long mean.
    a_alert_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alert) |-> (m_short_average > m_long_average))
        else $error("alert without a rise of the short mean");

    // The seeding counter only moves during the seeding pass.
    a_counter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SEED_RUN) |-> (run_cnt_reg == '0))
        else $error("seed counter running outside the seeding pass");

    // The cell rows shift only while a sample is taken or the windows are seeded.
    a_shift_states: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_en |-> ((state_reg == ST_UPDATE) || (state_reg == ST_SEED_RUN)))
        else $error("window shift outside an update or seeding cycle");

endmodule
